// File: src/kpsd_pkg.sv
// Shared types and constants for the keypad scan/debounce/one-shot block.
// Holds the poll item layout, register indexes and the fixed key table.
// No dependencies.
`default_nettype none

package kpsd_pkg;

    localparam int CODE_W    = 8;
    localparam int INDEX_W   = 5;
    localparam int NIBBLE_W  = 4;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NONE_CODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_CODE = 1'd1;

    // Reset values of the configuration registers
    localparam logic [CODE_W-1:0] NONE_CODE_RST  = 8'h00;
    localparam logic [CODE_W-1:0] POWER_CODE_RST = 8'h80;

    // Key table: sixteen fixed entries, power_code is entry sixteen
    localparam int KEY_FIXED = 16;
    localparam logic [INDEX_W-1:0] KEY_IDX_POWER  = 5'd16;
    localparam logic [INDEX_W-1:0] KEY_IDX_ABSENT = 5'd17;

    typedef logic [CODE_W-1:0] code_t;
    typedef code_t key_table_t [KEY_FIXED];

    localparam key_table_t KEY_TABLE = '{
        8'h01, 8'h11, 8'h31, 8'h71,
        8'h02, 8'h12, 8'h32, 8'h72,
        8'h74, 8'h78, 8'h04, 8'h14,
        8'h34, 8'h08, 8'h18, 8'h38
    };

    // One poll: two samples plus the power-on flag (lowest field last here)
    typedef struct packed {
        logic                power_on;
        logic                second_power_low;
        logic [NIBBLE_W-1:0] second_col;
        logic [NIBBLE_W-1:0] second_row;
        logic                first_power_low;
        logic [NIBBLE_W-1:0] first_col;
        logic [NIBBLE_W-1:0] first_row;
    } poll_t;

    // One result item
    typedef struct packed {
        logic               beep_request;
        logic [INDEX_W-1:0] key_index;
        code_t              key_code;
    } result_t;

endpackage

`default_nettype wire

// File: src/kpsd_decode.sv
// Decodes one keypad sample (row, column, power pin) into a key code.
// Depends on kpsd_pkg.
`default_nettype none

module kpsd_decode
    import kpsd_pkg::*;
(
    input  wire logic [NIBBLE_W-1:0] row,
    input  wire logic [NIBBLE_W-1:0] col,
    input  wire logic                power_low,
    input  wire code_t               none_code,
    input  wire code_t               power_code,
    output code_t                    code
);

    // col*16 + 255 - row, mod 256, is {col-1, ~row}
    always_comb
    begin
        code = none_code;
        if (row != {NIBBLE_W{1'b1}} && col != '0)
        begin
            code = {col - NIBBLE_W'(1), ~row};
        end
        if (power_low)
        begin
            code = power_code;
        end
    end

endmodule

`default_nettype wire

// File: src/kpsd_lookup.sv
// Finds the first position of a code in the key table.
// Depends on kpsd_pkg.
`default_nettype none

module kpsd_lookup
    import kpsd_pkg::*;
(
    input  wire code_t               code,
    input  wire code_t               power_code,
    output logic [INDEX_W-1:0]       key_index
);

    // Priority match: lowest table position wins, then the power entry
    always_comb
    begin
        key_index = KEY_IDX_ABSENT;
        if (code == power_code)
        begin
            key_index = KEY_IDX_POWER;
        end
        for (int i = KEY_FIXED - 1; i >= 0; i--)
        begin
            if (KEY_TABLE[i] == code)
            begin
                key_index = INDEX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: src/keypad_scan_debounce_oneshot_top.sv
// The result passes through the input register and then the result register; a
// full result register that is not taken holds the poll in the input register.
// Throughput: one poll per cycle while m_axis_tready does not stall; the output
// register lets a new poll into the empty input register while a result waits.
// Reset (rst_n, async, active low): pipeline empty, none_code = 0x00,
// power_code = 0x80, held key = 0x00. Depends on kpsd_pkg, kpsd_decode,
// kpsd_lookup.
`default_nettype none

module keypad_scan_debounce_oneshot_top
    import kpsd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Poll stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [3:0] first_row, [7:4] first_col, [8] first_power_low, [12:9] second_row,
    // [16:13] second_col, [17] second_power_low, [18] power_on, [23:19] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [7:0] key_code, [12:8] key_index, [13] beep_request, [15:14] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CODE_W-1:0]     cfg_data
);

    code_t   none_code_reg;
    code_t   power_code_reg;
    code_t   held_key_reg;
    code_t   held_key_next;
    logic    poll_valid_reg;
    poll_t   poll_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t out_next;
    logic    poll_advance;
    code_t   code_first;
    code_t   code_second;
    code_t   report;
    logic [INDEX_W-1:0] report_index;

    // Handshake: poll stage moves when the result register is free or being taken
    assign poll_advance  = poll_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !poll_valid_reg || poll_advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            none_code_reg  <= NONE_CODE_RST;
            power_code_reg <= POWER_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NONE_CODE:  none_code_reg  <= cfg_data;
                REG_POWER_CODE: power_code_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            poll_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            poll_reg <= poll_t'(s_axis_tdata[$bits(poll_t)-1:0]);
        end
    end

    // Sample decode
    kpsd_decode u_dec_first (
        .row        (poll_reg.first_row),
        .col        (poll_reg.first_col),
        .power_low  (poll_reg.first_power_low),
        .none_code  (none_code_reg),
        .power_code (power_code_reg),
        .code       (code_first)
    );

    kpsd_decode u_dec_second (
        .row        (poll_reg.second_row),
        .col        (poll_reg.second_col),
        .power_low  (poll_reg.second_power_low),
        .none_code  (none_code_reg),
        .power_code (power_code_reg),
        .code       (code_second)
    );

    // One-shot: report a stable key once, release clears the held key
    always_comb
    begin
        report        = none_code_reg;
        held_key_next = held_key_reg;
        if (code_first != none_code_reg)
        begin
            if (code_second == code_first && held_key_reg != code_first)
            begin
                held_key_next = code_first;
                report        = code_first;
            end
        end
        else
        begin
            held_key_next = none_code_reg;
        end
    end

    kpsd_lookup u_lookup (
        .code       (report),
        .power_code (power_code_reg),
        .key_index  (report_index)
    );

    always_comb
    begin
        out_next.key_code     = report;
        out_next.key_index    = report_index;
        out_next.beep_request = (report != none_code_reg) && poll_reg.power_on;
    end

    // Held key and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_key_reg  <= NONE_CODE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (poll_advance)
            begin
                held_key_reg <= held_key_next;
            end
            if (!out_valid_reg || m_axis_tready)
            begin
                out_valid_reg <= poll_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_advance)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// File: src/kpsd_checker.sv
// Port-level checks for the keypad scan/debounce/one-shot top level.
// Depends on kpsd_pkg; bound to keypad_scan_debounce_oneshot_top below.
`default_nettype none

module kpsd_checker
    import kpsd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Empty result register never back-pressures the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // Table index stays within the table, the power entry and the absent marker
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[12:8] <= KEY_IDX_ABSENT)
        else $error("key index out of range");

    // Padding bits of the result are zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:14] == 2'b00)
        else $error("result padding not zero");

endmodule

bind keypad_scan_debounce_oneshot_top kpsd_checker u_kpsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
